FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent that implies a consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)

`endif

`endif

FILE: rtl/ptd_pkg.sv
// ---------------------------------------------------------------------------
// Periodic task dispatcher package
// Command and status codes, field widths, result record and handle helper.
// ---------------------------------------------------------------------------
`default_nettype none

package ptd_pkg;

   localparam int TASKS_DEFAULT = 8;

   localparam int HANDLE_W   = 4;
   localparam int PERIOD_W   = 15;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [1:0] {
      CMD_CREATE = 2'd0,
      CMD_TICK   = 2'd1,
      CMD_POLL   = 2'd2,
      CMD_FORCE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_WAITING  = 2'd0,
      ST_READY    = 2'd1,
      ST_INIT     = 2'd2,
      ST_FINISHED = 2'd3
   } status_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] new_handle;
      logic [HANDLE_W-1:0] visited_handle;
      logic                init_called;
      logic                run_valid;
      logic [HANDLE_W-1:0] run_handle;
   } result_type;

   // Handle of a slot is the slot number plus one, kept to four bits.
   function automatic logic [HANDLE_W-1:0] handle_of(input logic [6:0] slot);
      logic [6:0] sum;
      sum = slot + 7'd1;
      return sum[HANDLE_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/periodic_task_dispatcher_top.sv
// One request at a time: req_tready is high only in idle, and a new request is
// taken once the result of the last one has moved to the output register;
// create and tick walk the table one slot a cycle, tick through a single
// decrementer. Reset (synchronous, active high) frees every slot and zeroes
// the scan pointer.
// ---------------------------------------------------------------------------
// Periodic task dispatcher
// Cooperative round-robin scheduler over a table of task slots, driven by
// create, tick, poll and force requests, one result per request.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module periodic_task_dispatcher_top
   import ptd_pkg::*;
#(
   parameter int TASKS = TASKS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [0] with_init, [1] with_run, [16:2] task_period, [20:17] target_handle,
   // [21] init_ok, [23:22] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] cmd
   input  wire logic [1:0]            req_tuser,

   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [3:0] new_handle, [7:4] visited_handle, [8] init_called,
   // [12:9] run_handle, [15:13] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // [0] run_valid
   output logic [0:0]                 rsp_tuser
);

   // Slot index width and a counter width that can also hold TASKS itself.
   localparam int SLOT_W = (TASKS > 1) ? $clog2(TASKS) : 1;
   localparam int CNT_W  = $clog2(TASKS + 1);
   localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(TASKS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASKS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CREATE,
      S_TICK,
      S_POLL_RD,
      S_POLL_EX,
      S_FORCE,
      S_DONE
   } state_type;

   // Sequencer and captured request.
   state_type            state_ff, state_in;
   logic                 with_init_ff, with_init_in;
   logic                 with_run_ff, with_run_in;
   logic [PERIOD_W-1:0]  period_ff, period_in;
   logic [HANDLE_W-1:0]  target_ff, target_in;
   logic                 init_ok_ff, init_ok_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   // Tick pipeline: the slot whose countdown read is returning this cycle.
   logic                 pend_ff, pend_in;
   logic [SLOT_W-1:0]    pend_slot_ff, pend_slot_in;

   // Per-slot flags and status live in flip-flops so that reset clears them.
   logic [TASKS-1:0]     used_ff, used_in;
   logic [TASKS-1:0]     has_init_ff, has_init_in;
   logic [TASKS-1:0]     has_run_ff, has_run_in;
   status_type           status_ff [TASKS];
   status_type           status_in [TASKS];
   logic [SLOT_W-1:0]    scan_ff, scan_in;

   // Result being built, and the output register.
   result_type           res_ff, res_in;
   result_type           rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Period and countdown memories: one write and one registered read a cycle.
   logic [PERIOD_W-1:0]  cd_mem  [TASKS];
   logic [PERIOD_W-1:0]  per_mem [TASKS];
   logic [PERIOD_W-1:0]  cd_rd_ff;
   logic [PERIOD_W-1:0]  per_rd_ff;
   logic [SLOT_W-1:0]    rd_addr;
   logic                 cd_we;
   logic                 per_we;
   logic [SLOT_W-1:0]    wr_addr;
   logic [PERIOD_W-1:0]  cd_wdata;

   // Decoded helpers.
   logic [SLOT_W-1:0]    cnt_slot;
   logic [6:0]           tgt_wide;
   logic [6:0]           tgt_m1;
   logic [SLOT_W-1:0]    tgt_slot;
   logic                 tgt_ok;

   assign cnt_slot = cnt_ff[SLOT_W-1:0];
   assign tgt_wide = 7'(target_ff);
   assign tgt_m1   = tgt_wide - 7'd1;
   assign tgt_slot = tgt_m1[SLOT_W-1:0];
   assign tgt_ok   = (target_ff != '0) && (tgt_wide <= 7'(TASKS));

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.run_handle, rsp_ff.init_called,
                        rsp_ff.visited_handle, rsp_ff.new_handle};
   assign rsp_tuser  = rsp_ff.run_valid;

   always_comb begin
      status_type          st;
      logic [PERIOD_W-1:0] cd;

      state_in     = state_ff;
      with_init_in = with_init_ff;
      with_run_in  = with_run_ff;
      period_in    = period_ff;
      target_in    = target_ff;
      init_ok_in   = init_ok_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      pend_slot_in = pend_slot_ff;
      used_in      = used_ff;
      has_init_in  = has_init_ff;
      has_run_in   = has_run_ff;
      status_in    = status_ff;
      scan_in      = scan_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      rd_addr      = scan_ff;
      cd_we        = 1'b0;
      per_we       = 1'b0;
      wr_addr      = scan_ff;
      cd_wdata     = cd_rd_ff;
      st           = status_ff[scan_ff];
      cd           = cd_rd_ff;

      // A waiting result leaves once the far side takes it.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               with_init_in = req_tdata[0];
               with_run_in  = req_tdata[1];
               period_in    = req_tdata[16:2];
               target_in    = req_tdata[20:17];
               init_ok_in   = req_tdata[21];
               cnt_in       = '0;
               res_in       = '0;
               case (cmd_type'(req_tuser))
                  CMD_CREATE: state_in = S_CREATE;
                  CMD_TICK:   state_in = S_TICK;
                  CMD_POLL:   state_in = S_POLL_RD;
                  CMD_FORCE:  state_in = S_FORCE;
                  default:    state_in = S_DONE;
               endcase
            end
         end

         S_CREATE: begin
            // Look at one slot a cycle; the first free one is taken.
            if (cnt_ff == LAST_CNT) begin
               state_in = S_DONE;
            end else if (!used_ff[cnt_slot]) begin
               used_in[cnt_slot]     = 1'b1;
               has_init_in[cnt_slot] = with_init_ff;
               has_run_in[cnt_slot]  = with_run_ff;
               status_in[cnt_slot]   = with_init_ff ? ST_INIT :
                                       (with_run_ff ? ST_READY : ST_WAITING);
               cd_we                 = 1'b1;
               per_we                = 1'b1;
               wr_addr               = cnt_slot;
               cd_wdata              = period_ff;
               res_in.new_handle     = handle_of(7'(cnt_slot));
               state_in              = S_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         S_TICK: begin
            // Read slot cnt while the decrementer works on the previous slot.
            rd_addr      = cnt_slot;
            pend_slot_in = cnt_slot;
            if (cnt_ff != LAST_CNT) begin
               pend_in = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
            end else begin
               state_in = S_DONE;
            end
            if (pend_ff && (status_ff[pend_slot_ff] == ST_READY) && (cd_rd_ff != '0)) begin
               cd_we    = 1'b1;
               wr_addr  = pend_slot_ff;
               cd_wdata = cd_rd_ff - 1'b1;
            end
         end

         S_POLL_RD: begin
            rd_addr  = scan_ff;
            state_in = S_POLL_EX;
         end

         S_POLL_EX: begin
            res_in.visited_handle = handle_of(7'(scan_ff));
            if (has_init_ff[scan_ff] && (st == ST_INIT)) begin
               res_in.init_called = 1'b1;
               st = init_ok_ff ? ST_READY : ST_WAITING;
            end
            if (has_run_ff[scan_ff]) begin
               // A finished task whose countdown has run out is rearmed first.
               if ((st == ST_FINISHED) && (cd == '0)) begin
                  cd       = per_rd_ff;
                  st       = ST_READY;
                  cd_we    = 1'b1;
                  wr_addr  = scan_ff;
                  cd_wdata = per_rd_ff;
               end
               if ((st == ST_READY) && (cd == '0)) begin
                  st                = ST_FINISHED;
                  res_in.run_valid  = 1'b1;
                  res_in.run_handle = handle_of(7'(scan_ff));
               end
            end
            status_in[scan_ff] = st;
            scan_in  = (scan_ff == LAST_SLOT) ? '0 : scan_ff + 1'b1;
            state_in = S_DONE;
         end

         S_FORCE: begin
            if (tgt_ok && used_ff[tgt_slot] && has_run_ff[tgt_slot]) begin
               status_in[tgt_slot] = ST_FINISHED;
               res_in.run_valid    = 1'b1;
               res_in.run_handle   = handle_of(7'(tgt_slot));
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            // Hand the result over once the output register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         used_ff      <= '0;
         has_init_ff  <= '0;
         has_run_ff   <= '0;
         for (int i = 0; i < TASKS; i++) begin
            status_ff[i] <= ST_WAITING;
         end
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         with_init_ff <= with_init_in;
         with_run_ff  <= with_run_in;
         period_ff    <= period_in;
         target_ff    <= target_in;
         init_ok_ff   <= init_ok_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         pend_slot_ff <= pend_slot_in;
         used_ff      <= used_in;
         has_init_ff  <= has_init_in;
         has_run_ff   <= has_run_in;
         status_ff    <= status_in;
         scan_ff      <= scan_in;
         res_ff       <= res_in;
         rsp_ff       <= rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cd_we) begin
         cd_mem[wr_addr] <= cd_wdata;
      end
      if (per_we) begin
         per_mem[wr_addr] <= period_ff;
      end
      cd_rd_ff  <= cd_mem[rd_addr];
      per_rd_ff <= per_mem[rd_addr];
   end

   `ASSERT_ALWAYS(a_scan_in_range, clock, reset, scan_ff <= LAST_SLOT, "scan pointer beyond table")
   `ASSERT_IMPLY(a_walk_bounded, clock, reset, (state_ff == S_CREATE) || (state_ff == S_TICK), cnt_ff <= LAST_CNT, "slot walk overran table")
   `ASSERT_IMPLY(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_DONE), "result raised outside completion")
   `ASSERT_IMPLY(a_create_alone, clock, reset, rsp_valid_ff && (rsp_ff.new_handle != '0), !rsp_ff.run_valid && !rsp_ff.init_called && (rsp_ff.visited_handle == '0), "create result mixed with poll fields")

endmodule

`default_nettype wire
